/* rtl/rtf_pkg.sv */
// Shared types and codes for the route table with freshness.
// Used by rtf_cfg and route_table_freshness; no dependencies.
package rtf_pkg;

    // APB register map: one 32-bit register, byte address 4*index
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [0:0] REG_LIFETIME = 1'b0;
    localparam logic [31:0] LIFETIME_RESET = 32'd60000;

    // Command codes
    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_QUERY  = 3'd2;
    localparam logic [2:0] CMD_INVAL  = 3'd3;
    localparam logic [2:0] CMD_SWEEP  = 3'd4;

    // Status codes
    localparam logic [2:0] ST_UPDATED   = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_REFRESHED = 3'd2;
    localparam logic [2:0] ST_REJECTED  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_HIT       = 3'd5;
    localparam logic [2:0] ST_MISS      = 3'd6;
    localparam logic [2:0] ST_EXPIRED   = 3'd7;

    localparam logic [7:0] ADDR_BCAST = 8'hFF;
    localparam logic [7:0] HOPS_NONE  = 8'hFF;
    localparam logic [4:0] SWEPT_MAX  = 5'd31;

    typedef struct packed {
        logic [7:0]  dest;
        logic [7:0]  next;
        logic [7:0]  hops;
        logic [31:0] seq;
        logic [31:0] stamp;
        logic [31:0] life;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* rtl/rtf_cfg.sv */
// APB configuration register for the route table (route lifetime).
// Depends on rtf_pkg for the register map and reset value.
module rtf_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtf_pkg::PADDR_W-1:0] paddr,
    input  logic [rtf_pkg::PDATA_W-1:0] pwdata,
    output logic [rtf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [31:0]                 o_lifetime
);
    import rtf_pkg::*;

    logic [31:0] r_lifetime;
    logic        sel_life;

    assign sel_life = (paddr[PADDR_W-1:2] == REG_LIFETIME);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LIFETIME_RESET;
        end else if (psel && penable && pwrite && sel_life) begin
            r_lifetime <= pwdata;
        end
    end

    assign prdata     = sel_life ? r_lifetime : '0;
    assign pready     = 1'b1;
    assign o_lifetime = r_lifetime;

endmodule

/* rtl/route_table_freshness.sv */
// Route table with freshness: top level with scan sequencer and entry memory.
// Depends on rtf_pkg and rtf_cfg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command item: add,
//   lookup with refresh, query, invalidate or expiry sweep. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result item per command.
//   The route lifetime register sits on the APB port at byte address 0.
//   Timing: an accepted item reads every table entry from the entry memory
//   through its one read port, one entry per cycle, then resolves and writes
//   back in the done state. A new item is accepted only after the previous
//   one has written back; the scan through the one memory read port limits
//   the rate of items.
//   The result sits in an output register; the next item is accepted while
//   it waits. When the receiver stalls, the result holds and a following
//   item finishes its scan and then waits before write-back.
//   Reset clears all valid bits and the lifetime returns to 60000 ms; the
//   block is ready for an item in the first cycle after reset.
module route_table_freshness #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_cmd,
    input  logic [7:0]                  i_dest,
    input  logic [7:0]                  i_via_hop,
    input  logic [7:0]                  i_hops_in,
    input  logic [31:0]                 i_seq_in,
    input  logic [31:0]                 i_now_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_status,
    output logic [7:0]                  o_route_hop,
    output logic [7:0]                  o_route_hops,
    output logic [31:0]                 o_route_seq,
    output logic [4:0]                  o_swept,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtf_pkg::PADDR_W-1:0] paddr,
    input  logic [rtf_pkg::PDATA_W-1:0] pwdata,
    output logic [rtf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import rtf_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    logic [31:0] lifetime;

    rtf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_lifetime (lifetime)
    );

    // Control state
    t_state r_state, n_state;
    logic   r_issuing;
    logic   r_rd_vld;
    logic   [IW-1:0] r_addr;
    logic   [IW-1:0] r_chk;
    logic   [ENTRIES-1:0] r_valid;
    logic   r_found;
    logic   r_free_found;
    logic   r_out_valid;

    // Item and scan payload
    logic [2:0]    r_cmd;
    logic [7:0]    r_dest;
    logic [7:0]    r_via;
    logic [7:0]    r_hops;
    logic [31:0]   r_seq;
    logic [31:0]   r_now;
    logic [IW-1:0] r_fidx;
    logic [IW-1:0] r_free_idx;
    t_entry        r_fdata;
    logic [4:0]    r_swept;

    // Entry memory
    t_entry r_mem [ENTRIES];
    t_entry r_rd_data;

    logic   [2:0]  r_status;
    logic   [7:0]  r_out_hop;
    logic   [7:0]  r_out_hops;
    logic   [31:0] r_out_seq;
    logic   [4:0]  r_out_swept;

    logic accept, scan_en, done_en, slot_free, last_eval;

    // Scan evaluation
    logic        chk_valid;
    logic        chk_match;
    logic [31:0] chk_age;
    logic        chk_stale;

    // Write-back decision
    logic          we;
    logic [IW-1:0] waddr;
    t_entry        wdata;
    logic          set_v, clr_v;
    logic [IW-1:0] v_idx;
    logic [2:0]    d_status;
    logic [7:0]    d_hop, d_hops;
    logic [31:0]   d_seq;
    logic [4:0]    d_swept;
    logic [31:0]   f_age;
    t_entry        new_route;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign last_eval = !r_issuing && r_rd_vld;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_SCAN;
            S_SCAN: if (last_eval) n_state = S_DONE;
            S_DONE: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        accept     = (r_state == S_IDLE) && i_in_valid;
        scan_en    = (r_state == S_SCAN);
        done_en    = (r_state == S_DONE) && slot_free;
    end

    assign chk_valid = r_valid[r_chk];
    assign chk_match = chk_valid && (r_rd_data.dest == r_dest);
    assign chk_age   = r_now - r_rd_data.stamp;
    assign chk_stale = chk_valid && (chk_age > r_rd_data.life);

    assign new_route = '{dest: r_dest, next: r_via, hops: r_hops, seq: r_seq,
                         stamp: r_now, life: lifetime};
    assign f_age = r_now - r_fdata.stamp;

    always_comb begin
        we       = 1'b0;
        waddr    = r_fidx;
        wdata    = r_fdata;
        set_v    = 1'b0;
        clr_v    = 1'b0;
        v_idx    = r_fidx;
        d_status = ST_MISS;
        d_hop    = ADDR_BCAST;
        d_hops   = HOPS_NONE;
        d_seq    = '0;
        d_swept  = '0;
        unique case (r_cmd)
            CMD_ADD: begin
                if (r_found) begin
                    if ((r_seq > r_fdata.seq) ||
                        (r_seq == r_fdata.seq && r_hops < r_fdata.hops)) begin
                        we       = 1'b1;
                        wdata    = new_route;
                        d_status = ST_UPDATED;
                    end else if (r_seq == r_fdata.seq && r_hops == r_fdata.hops &&
                                 r_via == r_fdata.next) begin
                        we          = 1'b1;
                        wdata.stamp = r_now;
                        wdata.life  = lifetime;
                        d_status    = ST_REFRESHED;
                    end else begin
                        d_status = ST_REJECTED;
                    end
                end else if (r_free_found) begin
                    we       = 1'b1;
                    waddr    = r_free_idx;
                    wdata    = new_route;
                    set_v    = 1'b1;
                    v_idx    = r_free_idx;
                    d_status = ST_INSERTED;
                end else begin
                    d_status = ST_FULL;
                end
            end
            CMD_LOOKUP, CMD_QUERY: begin
                if (r_found) begin
                    if (f_age < r_fdata.life) begin
                        if (r_cmd == CMD_LOOKUP) begin
                            we          = 1'b1;
                            wdata.stamp = r_now;
                        end
                        d_status = ST_HIT;
                        d_hop    = r_fdata.next;
                        d_hops   = r_fdata.hops;
                        d_seq    = r_fdata.seq;
                    end else begin
                        clr_v    = 1'b1;
                        d_status = ST_EXPIRED;
                    end
                end
            end
            CMD_INVAL: begin
                if (r_found) begin
                    clr_v    = 1'b1;
                    d_status = ST_HIT;
                end
            end
            CMD_SWEEP: begin
                d_swept  = r_swept;
                d_status = (r_swept != '0) ? ST_EXPIRED : ST_MISS;
            end
            default: d_status = ST_MISS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_issuing    <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_addr       <= '0;
            r_valid      <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_issuing    <= 1'b1;
                r_rd_vld     <= 1'b0;
                r_addr       <= '0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else if (scan_en) begin
                r_rd_vld <= r_issuing;
                if (r_issuing) begin
                    if (r_addr == LAST_IDX) begin
                        r_issuing <= 1'b0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    if (chk_match && !r_found) r_found <= 1'b1;
                    if (!chk_valid && !r_free_found) r_free_found <= 1'b1;
                    // sweep drops stale entries as they pass
                    if (r_cmd == CMD_SWEEP && chk_stale) r_valid[r_chk] <= 1'b0;
                end
            end else if (done_en) begin
                if (set_v) r_valid[v_idx] <= 1'b1;
                if (clr_v) r_valid[v_idx] <= 1'b0;
            end
            if (done_en) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_dest  <= i_dest;
            r_via   <= i_via_hop;
            r_hops  <= i_hops_in;
            r_seq   <= i_seq_in;
            r_now   <= i_now_ms;
            r_swept <= '0;
        end else if (scan_en) begin
            r_chk <= r_addr;
            if (r_rd_vld) begin
                if (chk_match && !r_found) begin
                    r_fidx  <= r_chk;
                    r_fdata <= r_rd_data;
                end
                if (!chk_valid && !r_free_found) r_free_idx <= r_chk;
                if (r_cmd == CMD_SWEEP && chk_stale && r_swept != SWEPT_MAX) begin
                    r_swept <= r_swept + 1'b1;
                end
            end
        end
        if (done_en) begin
            r_status    <= d_status;
            r_out_hop   <= d_hop;
            r_out_hops  <= d_hops;
            r_out_seq   <= d_seq;
            r_out_swept <= d_swept;
        end
    end

    // Read data is used only during the scan, writes only at write-back: no overlap
    always_ff @(posedge i_clk) begin
        if (done_en && we) r_mem[waddr] <= wdata;
        r_rd_data <= r_mem[r_addr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_route_hop  = r_out_hop;
    assign o_route_hops = r_out_hops;
    assign o_route_seq  = r_out_seq;
    assign o_swept      = r_out_swept;

endmodule
